// File: rtl/core/sha1_message_digest_core_assert.svh
// Assertion macros for the SHA-1 message digest core.
// Used by the top level; expects clk and rst_n in scope.
`ifndef SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH
`define SHA1_MESSAGE_DIGEST_CORE_ASSERT_SVH
`ifndef SYNTHESIS
// lbl: label, prop: property expression checked at every clock edge
`define SHA1MD_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("sha1md: check failed");
// ante holds in one cycle, cons must hold in the next
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sha1md: sequence check failed");
`else
`define SHA1MD_ASSERT(lbl, prop)
`define SHA1MD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// File: rtl/core/sha1md_pkg.sv
// Shared types, constants and helper functions of the SHA-1 digest core.
// No dependencies.
package sha1md_pkg;

    localparam int NumWords = 5;
    localparam int Rounds   = 80;
    localparam int BlkBytes = 64;

    typedef logic [31:0] word_t;
    typedef logic [5:0]  bpos_t;
    typedef logic [6:0]  round_t;

    localparam bpos_t  LAST_POS   = bpos_t'(BlkBytes - 1);
    localparam bpos_t  LEN_POS    = 6'd56;
    localparam round_t LAST_ROUND = round_t'(Rounds - 1);
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef enum logic [1:0] {
        PH_CH,
        PH_PAR1,
        PH_MAJ,
        PH_PAR2
    } phase_t;

    typedef struct packed {
        word_t a;
        word_t b;
        word_t c;
        word_t d;
        word_t e;
    } work_t;

    // Control from the sequencer to the block buffer / schedule
    typedef struct packed {
        logic       wr_en;
        bpos_t      wr_pos;
        logic [7:0] wr_byte;
        logic       shift_en;
        logic       expand;
    } sched_ctl_t;

    function automatic word_t iv_word(input logic [2:0] idx);
        word_t w;
        case (idx)
            3'd0:    w = 32'h67452301;
            3'd1:    w = 32'hEFCDAB89;
            3'd2:    w = 32'h98BADCFE;
            3'd3:    w = 32'h10325476;
            default: w = 32'hC3D2E1F0;
        endcase
        return w;
    endfunction

    function automatic word_t round_k(input phase_t ph);
        word_t k;
        unique case (ph)
            PH_CH:   k = 32'h5A827999;
            PH_PAR1: k = 32'h6ED9EBA1;
            PH_MAJ:  k = 32'h8F1BBCDC;
            default: k = 32'hCA62C1D6;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/core/sha1_message_digest_core.sv
// SHA-1 digest core, one message byte per request, five digest words out.
// A byte request writes the byte into the block buffer; the 64th byte of a block
// also starts a compression (80 rounds on the shared round unit, then a fold into
// the chaining words). End of message: padding bytes plus one or two compressions,
// then five result words. Requests are taken only while idle; one request at a time.
// Reset (rst_n, asynchronous): idle, chaining words at the initial values, count zero.
module sha1_message_digest_core
    import sha1md_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        message_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

`include "sha1_message_digest_core_assert.svh"

    typedef enum logic [2:0] {
        S_IDLE,
        S_ROUND,
        S_ADD,
        S_PAD,
        S_OUT
    } state_t;

    state_t        state_reg, state_next;
    round_t        round_reg, round_next;
    work_t         work_reg, work_next;
    word_t         chain_reg [NumWords];
    word_t         chain_next [NumWords];
    logic [60:0]   count_reg, count_next;
    bpos_t         pad_pos_reg, pad_pos_next;
    logic          pad_first_reg, pad_first_next;
    logic          len_blk_reg, len_blk_next;
    logic          pad_active_reg, pad_active_next;
    logic          end_pend_reg, end_pend_next;
    logic [2:0]    idx_reg, idx_next;

    sched_ctl_t    sched_ctl;
    word_t         wt;
    work_t         round_out;
    work_t         chain_work;
    phase_t        phase;
    logic [63:0]   bit_len;
    logic [7:0]    len_byte;
    logic [7:0]    pad_byte;
    bpos_t         start_pos;

    sha1md_sched u_sched (
        .clk (clk),
        .ctl (sched_ctl),
        .wt  (wt)
    );

    sha1md_round u_round (
        .cur   (work_reg),
        .phase (phase),
        .wt    (wt),
        .nxt   (round_out)
    );

    always_comb
    begin
        if (round_reg < 7'd20)
            phase = PH_CH;
        else if (round_reg < 7'd40)
            phase = PH_PAR1;
        else if (round_reg < 7'd60)
            phase = PH_MAJ;
        else
            phase = PH_PAR2;

        chain_work = {chain_reg[0], chain_reg[1], chain_reg[2], chain_reg[3], chain_reg[4]};
        bit_len    = {count_reg, 3'b000};
        len_byte   = bit_len[{~pad_pos_reg[2:0], 3'b000} +: 8];

        // 0x80 first, zero fill, bit length in the last eight bytes of the final block
        if (pad_first_reg)
            pad_byte = PAD_BYTE;
        else if (len_blk_reg && pad_pos_reg >= LEN_POS)
            pad_byte = len_byte;
        else
            pad_byte = 8'h00;

        start_pos = count_reg[5:0] + bpos_t'(byte_present);

        sched_ctl.shift_en = (state_reg == S_ROUND);
        sched_ctl.expand   = (round_reg[6:4] != 3'd0);
        sched_ctl.wr_en    = (state_reg == S_PAD) ||
                             (state_reg == S_IDLE && in_valid && byte_present);
        sched_ctl.wr_pos   = (state_reg == S_PAD) ? pad_pos_reg : count_reg[5:0];
        sched_ctl.wr_byte  = (state_reg == S_PAD) ? pad_byte : data_byte;
    end

    always_comb
    begin
        state_next      = state_reg;
        round_next      = round_reg;
        work_next       = work_reg;
        chain_next      = chain_reg;
        count_next      = count_reg;
        pad_pos_next    = pad_pos_reg;
        pad_first_next  = pad_first_reg;
        len_blk_next    = len_blk_reg;
        pad_active_next = pad_active_reg;
        end_pend_next   = end_pend_reg;
        idx_next        = idx_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (byte_present)
                        count_next = count_reg + 61'd1;
                    if (byte_present && count_reg[5:0] == LAST_POS)
                    begin
                        // block full: compress, remember a pending end
                        state_next      = S_ROUND;
                        round_next      = '0;
                        work_next       = chain_work;
                        end_pend_next   = message_end;
                        pad_active_next = 1'b0;
                    end
                    else if (message_end)
                    begin
                        state_next      = S_PAD;
                        pad_pos_next    = start_pos;
                        pad_first_next  = 1'b1;
                        len_blk_next    = (start_pos < LEN_POS);
                        pad_active_next = 1'b1;
                    end
                end
            end
            S_ROUND:
            begin
                work_next  = round_out;
                round_next = round_reg + 7'd1;
                if (round_reg == LAST_ROUND)
                    state_next = S_ADD;
            end
            S_ADD:
            begin
                chain_next[0] = chain_reg[0] + work_reg.a;
                chain_next[1] = chain_reg[1] + work_reg.b;
                chain_next[2] = chain_reg[2] + work_reg.c;
                chain_next[3] = chain_reg[3] + work_reg.d;
                chain_next[4] = chain_reg[4] + work_reg.e;
                if (pad_active_reg)
                begin
                    if (len_blk_reg)
                    begin
                        state_next = S_OUT;
                        idx_next   = '0;
                    end
                    else
                    begin
                        // padding spilled over: one more block carries the length
                        state_next   = S_PAD;
                        len_blk_next = 1'b1;
                        pad_pos_next = '0;
                    end
                end
                else if (end_pend_reg)
                begin
                    state_next      = S_PAD;
                    pad_pos_next    = '0;
                    pad_first_next  = 1'b1;
                    len_blk_next    = 1'b1;
                    pad_active_next = 1'b1;
                    end_pend_next   = 1'b0;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_PAD:
            begin
                pad_first_next = 1'b0;
                pad_pos_next   = pad_pos_reg + 6'd1;
                if (pad_pos_reg == LAST_POS)
                begin
                    state_next = S_ROUND;
                    round_next = '0;
                    work_next  = chain_work;
                end
            end
            S_OUT:
            begin
                if (out_ready)
                begin
                    if (idx_reg == 3'(NumWords - 1))
                    begin
                        // restart for the next message
                        for (int i = 0; i < NumWords; i++)
                        begin
                            chain_next[i] = iv_word(3'(i));
                        end
                        count_next      = '0;
                        pad_active_next = 1'b0;
                        state_next      = S_IDLE;
                    end
                    else
                    begin
                        idx_next = idx_reg + 3'd1;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            round_reg      <= '0;
            work_reg       <= '0;
            for (int i = 0; i < NumWords; i++)
            begin
                chain_reg[i] <= iv_word(3'(i));
            end
            count_reg      <= '0;
            pad_pos_reg    <= '0;
            pad_first_reg  <= 1'b0;
            len_blk_reg    <= 1'b0;
            pad_active_reg <= 1'b0;
            end_pend_reg   <= 1'b0;
            idx_reg        <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            round_reg      <= round_next;
            work_reg       <= work_next;
            chain_reg      <= chain_next;
            count_reg      <= count_next;
            pad_pos_reg    <= pad_pos_next;
            pad_first_reg  <= pad_first_next;
            len_blk_reg    <= len_blk_next;
            pad_active_reg <= pad_active_next;
            end_pend_reg   <= end_pend_next;
            idx_reg        <= idx_next;
        end
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign out_valid   = (state_reg == S_OUT);
    assign digest_word = chain_reg[idx_reg];
    assign word_index  = idx_reg;
    assign last_word   = (idx_reg == 3'(NumWords - 1));

    `SHA1MD_ASSERT(a_ready_excl, !(in_ready && out_valid))
    `SHA1MD_ASSERT(a_round_range, state_reg != S_ROUND || round_reg <= LAST_ROUND)
    `SHA1MD_ASSERT(a_index_range, !out_valid || word_index <= 3'(NumWords - 1))
    `SHA1MD_ASSERT_NEXT(a_done_idle, out_valid && out_ready && last_word, in_ready)

endmodule

// File: rtl/core/sha1md_sched.sv
// Block buffer and message schedule: sixteen words written byte by byte,
// then rotated and expanded one word per round. Depends on sha1md_pkg.
module sha1md_sched
    import sha1md_pkg::*;
(
    input  logic       clk,
    input  sched_ctl_t ctl,
    output word_t      wt
);

    word_t      w_reg [16];
    word_t      mix;
    word_t      expanded;
    logic [4:0] lane_sh;

    always_comb
    begin
        mix      = w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0];
        expanded = {mix[30:0], mix[31]};
        wt       = ctl.expand ? expanded : w_reg[0];
        // big-endian: byte 0 of a word lands in bits 31:24
        lane_sh  = {~ctl.wr_pos[1:0], 3'b000};
    end

    always_ff @(posedge clk)
    begin
        if (ctl.shift_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                w_reg[i] <= w_reg[i + 1];
            end
            w_reg[15] <= wt;
        end
        else if (ctl.wr_en)
        begin
            w_reg[ctl.wr_pos[5:2]][lane_sh +: 8] <= ctl.wr_byte;
        end
    end

endmodule

// File: rtl/core/sha1md_round.sv
// One SHA-1 round: boolean function, constant and five-operand add.
// Depends on sha1md_pkg.
module sha1md_round
    import sha1md_pkg::*;
(
    input  work_t  cur,
    input  phase_t phase,
    input  word_t  wt,
    output work_t  nxt
);

    word_t f;
    word_t t_sum;

    always_comb
    begin
        case (phase) inside
            PH_CH:            f = (cur.b & cur.c) | (~cur.b & cur.d);
            PH_PAR1, PH_PAR2: f = cur.b ^ cur.c ^ cur.d;
            default:          f = (cur.b & cur.c) | (cur.b & cur.d) | (cur.c & cur.d);
        endcase
        t_sum = {cur.a[26:0], cur.a[31:27]} + f + cur.e + round_k(phase) + wt;
        nxt.a = t_sum;
        nxt.b = cur.a;
        nxt.c = {cur.b[1:0], cur.b[31:2]};
        nxt.d = cur.c;
        nxt.e = cur.d;
    end

endmodule

// File: tb/sha1_message_digest_core_tb.sv
// Self-checking bench for sha1_message_digest_core: byte requests in, digest words out.
// Needs sha1md_pkg and the core; the SHA-1 prediction is computed here at each accepted request.
module sha1_message_digest_core_tb
    import sha1md_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam word_t IV0  = 32'h67452301;
    localparam word_t IV1  = 32'hEFCDAB89;
    localparam word_t IV2  = 32'h98BADCFE;
    localparam word_t IV3  = 32'h10325476;
    localparam word_t IV4  = 32'hC3D2E1F0;
    localparam word_t K_CH   = 32'h5A827999;
    localparam word_t K_PAR1 = 32'h6ED9EBA1;
    localparam word_t K_MAJ  = 32'h8F1BBCDC;
    localparam word_t K_PAR2 = 32'hCA62C1D6;

    localparam int RANDOM_ITEMS  = 320;
    localparam int TAIL_ITEMS    = 60;
    localparam int HOLD_AT       = 60;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 300;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct {
        logic [7:0] data;
        logic       present;
        logic       last;
    } hash_req_t;

    typedef struct {
        word_t      value;
        logic [2:0] index;
        logic       is_last;
    } digest_word_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte = 8'h00;
    logic        byte_present = 1'b0;
    logic        message_end = 1'b0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;

    // predictor state
    word_t       chain_state [5];
    logic [7:0]  blk_bytes [64];
    logic [60:0] msg_len;

    hash_req_t    pending_reqs [$];
    digest_word_t digest_due [$];

    int          total_items = 0;
    int          items_accepted = 0;
    int          error_count = 0;
    int unsigned cycle_count = 0;
    int          send_gap = 0;
    int          recv_gap = 0;
    int          hold_left = 0;
    logic        hold_done = 1'b0;
    logic        hold_active;

    sha1_message_digest_core i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .data_byte    (data_byte),
        .byte_present (byte_present),
        .message_end  (message_end),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .digest_word  (digest_word),
        .word_index   (word_index),
        .last_word    (last_word)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    task automatic flag_error(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        error_count++;
    endtask

    function automatic word_t rotl(input word_t x, input int unsigned s);
        return (x << s) | (x >> (32 - s));
    endfunction

    function automatic void restart_chain();
        chain_state[0] = IV0;
        chain_state[1] = IV1;
        chain_state[2] = IV2;
        chain_state[3] = IV3;
        chain_state[4] = IV4;
        msg_len = '0;
    endfunction

    function automatic void sha1_compress();
        word_t  w [80];
        word_t  a, b, c, d, e, f, k, nx;
        phase_t ph;
        for (int t = 0; t < 16; t++)
            w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
        for (int t = 16; t < 80; t++)
            w[t] = rotl(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
        a = chain_state[0];
        b = chain_state[1];
        c = chain_state[2];
        d = chain_state[3];
        e = chain_state[4];
        for (int t = 0; t < 80; t++)
        begin
            ph = phase_t'(t / 20);
            case (ph)
                PH_CH:
                begin
                    f = (b & c) | (~b & d);
                    k = K_CH;
                end
                PH_PAR1:
                begin
                    f = b ^ c ^ d;
                    k = K_PAR1;
                end
                PH_MAJ:
                begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_MAJ;
                end
                default:
                begin
                    f = b ^ c ^ d;
                    k = K_PAR2;
                end
            endcase
            nx = rotl(a, 5) + f + e + k + w[t];
            e = d;
            d = c;
            c = rotl(b, 30);
            b = a;
            a = nx;
        end
        chain_state[0] += a;
        chain_state[1] += b;
        chain_state[2] += c;
        chain_state[3] += d;
        chain_state[4] += e;
    endfunction

    // Advance the hash by one accepted request; a message end queues five digest words.
    function automatic void hash_request(input logic [7:0] data, input logic present,
                                         input logic last);
        bpos_t        pos;
        logic [63:0]  bit_len;
        digest_word_t dw;
        if (present)
        begin
            pos = msg_len[5:0];
            blk_bytes[pos] = data;
            msg_len = msg_len + 1'b1;
            if (pos == LAST_POS)
                sha1_compress();
        end
        if (!last)
            return;
        pos = msg_len[5:0];
        blk_bytes[pos] = PAD_BYTE;
        for (int i = int'(pos) + 1; i < 64; i++)
            blk_bytes[i] = 8'h00;
        // no room left for the length: spill into a second block
        if (pos >= LEN_POS)
        begin
            sha1_compress();
            for (int i = 0; i < 64; i++)
                blk_bytes[i] = 8'h00;
        end
        bit_len = {msg_len, 3'b000};
        for (int i = 0; i < 8; i++)
            blk_bytes[56 + i] = bit_len[8*(7-i) +: 8];
        sha1_compress();
        for (int i = 0; i < 5; i++)
        begin
            dw.value   = chain_state[i];
            dw.index   = 3'(i);
            dw.is_last = (i == 4);
            digest_due.push_back(dw);
        end
        restart_chain();
    endfunction

    function automatic void push_req(input logic [7:0] data, input logic present,
                                     input logic last);
        hash_req_t r;
        r.data    = data;
        r.present = present;
        r.last    = last;
        pending_reqs.push_back(r);
    endfunction

    // Queue one message with stray empty requests mixed in; return requests that count.
    function automatic int queue_message(input int len, input bit end_has_byte);
        int  body;
        bit  carry;
        carry = (len > 0) && end_has_byte;
        body  = carry ? len - 1 : len;
        for (int i = 0; i < body; i++)
        begin
            if ($urandom_range(0, 99) < 6)
                push_req(8'($urandom_range(0, 255)), 1'b0, 1'b0);
            push_req(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        end
        push_req(8'($urandom_range(0, 255)), carry, 1'b1);
        return carry ? len : len + 1;
    endfunction

    function automatic int pick_length();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel < 3)
            return $urandom_range(0, 3);
        if (sel < 5)
        begin
            case ($urandom_range(0, 9))
                0:       return 55;
                1:       return 56;
                2:       return 57;
                3:       return 63;
                4:       return 64;
                5:       return 65;
                6:       return 119;
                7:       return 120;
                8:       return 127;
                default: return 128;
            endcase
        end
        return $urandom_range(4, 70);
    endfunction

    function automatic bit idling_allowed();
        if (hold_active)
            return 1'b0;
        if (items_accepted >= total_items - TAIL_ITEMS)
            return 1'b0;
        return ((items_accepted / 32) % 3) != 2;
    endfunction

    assign hold_active = (hold_left != 0);

    // long receiver hold-off so the core backs up and stalls its input
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end
        else if (!hold_done && items_accepted >= HOLD_AT)
        begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : drive_requests
        hash_req_t r;
        if (!rst_n)
        begin
            in_valid     <= 1'b0;
            data_byte    <= 8'h00;
            byte_present <= 1'b0;
            message_end  <= 1'b0;
            send_gap     <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                hash_request(data_byte, byte_present, message_end);
                items_accepted <= items_accepted + 1;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pending_reqs.size() == 0)
                begin
                    in_valid <= 1'b0;
                end
                else if (idling_allowed() && $urandom_range(0, 3) == 0)
                begin
                    send_gap <= $urandom_range(0, 9);
                    in_valid <= 1'b0;
                end
                else
                begin
                    r = pending_reqs.pop_front();
                    data_byte    <= r.data;
                    byte_present <= r.present;
                    message_end  <= r.last;
                    in_valid     <= 1'b1;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin : check_digest
        digest_word_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (digest_due.size() == 0)
                begin
                    flag_error($sformatf("unexpected digest word %08h index %0d",
                                         digest_word, word_index));
                end
                else
                begin
                    want = digest_due.pop_front();
                    if (digest_word !== want.value)
                        flag_error($sformatf("digest_word %08h, want %08h",
                                             digest_word, want.value));
                    if (word_index !== want.index)
                        flag_error($sformatf("word_index %0d, want %0d",
                                             word_index, want.index));
                    if (last_word !== want.is_last)
                        flag_error($sformatf("last_word %0b, want %0b",
                                             last_word, want.is_last));
                end
            end
            if (hold_active)
            begin
                out_ready <= 1'b0;
            end
            else if (recv_gap != 0)
            begin
                recv_gap  <= recv_gap - 1;
                out_ready <= 1'b0;
            end
            else if (idling_allowed() && $urandom_range(0, 6) == 0)
            begin
                recv_gap  <= $urandom_range(0, 9);
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        while (cycle_count < CYCLE_LIMIT)
            @(posedge clk);
        $display("sha1_message_digest_core test failed");
        $finish;
    end

    initial
    begin : stimulus
        int counted;
        restart_chain();
        for (int i = 0; i < 64; i++)
            blk_bytes[i] = 8'h00;

        // empty message, then a stray request followed by another empty message
        push_req(8'h5A, 1'b0, 1'b1);
        push_req(8'hFF, 1'b0, 1'b0);
        push_req(8'h00, 1'b0, 1'b1);
        // byte extremes, end request carrying a byte
        push_req(8'h00, 1'b1, 1'b0);
        push_req(8'hFF, 1'b1, 1'b0);
        push_req(8'h80, 1'b1, 1'b1);
        // "abc"
        push_req(8'h61, 1'b1, 1'b0);
        push_req(8'h62, 1'b1, 1'b0);
        push_req(8'h63, 1'b1, 1'b1);
        // one byte, end on its own
        push_req(8'h7F, 1'b1, 1'b0);
        push_req(8'h01, 1'b0, 1'b1);

        counted = 0;
        while (counted < RANDOM_ITEMS)
            counted += queue_message(pick_length(), 1'($urandom_range(0, 1)));
        total_items = pending_reqs.size();

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (items_accepted < total_items)
            @(posedge clk);
        while (digest_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("sha1_message_digest_core test passed");
        else
            $display("sha1_message_digest_core test failed");
        $finish;
    end

endmodule

// File: files.f
+incdir+rtl/core
rtl/core/sha1md_pkg.sv
rtl/core/sha1md_sched.sv
rtl/core/sha1md_round.sv
rtl/core/sha1_message_digest_core.sv
tb/sha1_message_digest_core_tb.sv
